### src/mesh_neighbor_exchange_order_defines.svh
// Assertion macros shared by the mesh neighbor exchange order RTL.
// Depends on nothing; included by the top level only.
`ifndef MESH_NEIGHBOR_EXCHANGE_ORDER_DEFINES_SVH
`define MESH_NEIGHBOR_EXCHANGE_ORDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MNE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MNE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mne_pkg.sv
// Shared constants, codes and types of the mesh neighbor exchange order block.
// Depends on nothing; used by every block file but the assertion macro header.
package mne_pkg;

	localparam int RANK_W      = 12;
	localparam int CFG_W       = 7;
	localparam int AXIS_W      = 2;
	localparam int NUM_AXES    = 4;
	localparam int NUM_SLOTS   = 8;
	localparam int SLOT_W      = $clog2(NUM_SLOTS);
	localparam int QUEUE_DEPTH = 4;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	// Quotient bits the divider retires per cycle; its last step waits for stage 1.
	localparam int DIV_BITS    = 2;
	localparam int DIV_CYCLES  = RANK_W / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
	localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

	typedef enum logic [AXIS_W-1:0] {
		AXIS_HORIZ = 2'd0,
		AXIS_VERT  = 2'd1,
		AXIS_DIAG  = 2'd2,
		AXIS_ANTI  = 2'd3
	} axis_t;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	// One classified node: its rank, which of the eight ordered slots hold a
	// partner inside the grid, and the parity key of each axis.
	typedef struct packed {
		logic [RANK_W-1:0]    rank;
		logic [NUM_SLOTS-1:0] mask;
		logic [NUM_AXES-1:0]  keys;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

### src/mne_node_if.sv
// Request channel carrying one node rank with a valid/ready handshake.
// Depends on mne_pkg.
interface mne_node_if;
	import mne_pkg::*;

	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] node_rank;

	modport source(output valid, output node_rank, input ready);
	modport sink(input valid, input node_rank, output ready);
endinterface

### src/mne_partner_if.sv
// Result channel carrying one exchange partner with a valid/ready handshake.
// Depends on mne_pkg.
interface mne_partner_if;
	import mne_pkg::*;

	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] partner_rank;
	logic [AXIS_W-1:0] exchange_axis;
	logic              last_partner;

	modport source(output valid, output partner_rank, output exchange_axis,
		output last_partner, input ready);
	modport sink(input valid, input partner_rank, input exchange_axis,
		input last_partner, output ready);
endinterface

### src/mesh_neighbor_exchange_order.sv
// Top level of the mesh neighbor exchange order block: configuration
// registers, front end, queue and back end. Uses mne_pkg, both channel
// interfaces and the assertion macro header.
`include "mesh_neighbor_exchange_order_defines.svh"

// Each request carries the row-major rank of a node in a grid_width by
// grid_height mesh; the block answers with the ranks of the node's up to
// eight neighbors, one result per cycle while the receiver takes them,
// ordered horizontal, vertical, diagonal, anti-diagonal, with the pair on
// each axis swapped when the axis key (column, row, min(row, column) or
// min(row, width-1-column)) is odd. Neighbors outside the grid are skipped,
// a node without any neighbor gives no result at all, and the final result
// of a node has last_partner set. Register values of zero act as one and
// values above MAX_GRID_SIDE act as MAX_GRID_SIDE. The front end takes a
// new request only as its divider finishes the last; the divider splits the
// 12-bit rank into row and column and retires two quotient bits per cycle.
// The back end moves to the next queued node as it emits a node's final
// result. A four-entry queue between the two ends lets the divider keep
// working while results wait on the output. The first result passes through
// the divider, stage 1, the queue and the back end's node and output registers.
// The registers sit on an APB port at byte addresses 0 (grid_width) and 4
// (grid_height) and should only be written while the block is idle.
module mesh_neighbor_exchange_order #(
	parameter int MAX_GRID_SIDE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mne_node_if.sink                      node,
	mne_partner_if.source                 partner,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mne_pkg::PADDR_W-1:0]   paddr,
	input  logic [mne_pkg::PDATA_W-1:0]   pwdata,
	output logic [mne_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import mne_pkg::*;

	localparam int SIDE_W = $clog2(MAX_GRID_SIDE) + 1;

	// Raw register contents; the effective sides are clamped copies.
	logic [CFG_W-1:0]  grid_width_q;
	logic [CFG_W-1:0]  grid_height_q;
	logic [SIDE_W-1:0] grid_w, grid_h;

	logic              push, pop, cfg_wr;
	entry_t            push_entry, pop_entry;
	fifo_stat_t        q_stat;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return SIDE_W'(1);
		end
		if (int'(v) > MAX_GRID_SIDE) begin
			return SIDE_W'(MAX_GRID_SIDE);
		end
		return SIDE_W'(v);
	endfunction

	assign grid_w = clamp_side(grid_width_q);
	assign grid_h = clamp_side(grid_height_q);

	// APB: no wait states, register select by the word address bit.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_GRID_WIDTH:  prdata = {{(PDATA_W - CFG_W){1'b0}}, grid_width_q};
			REG_GRID_HEIGHT: prdata = {{(PDATA_W - CFG_W){1'b0}}, grid_height_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CFG_W'(1);
			grid_height_q <= CFG_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[CFG_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end divides and classifies; it only writes the queue when
	// the node has at least one partner inside the grid.
	mne_front #(
		.MAX_GRID_SIDE(MAX_GRID_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.node      (node),
		.grid_w    (grid_w),
		.grid_h    (grid_h),
		.q_full    (q_stat.full),
		.push      (push),
		.push_entry(push_entry)
	);

	mne_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (pop_entry),
		.stat      (q_stat)
	);

	// The back end turns each queued slot mask into partner results.
	mne_back #(
		.MAX_GRID_SIDE(MAX_GRID_SIDE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.grid_w   (grid_w),
		.stat     (q_stat),
		.pop_entry(pop_entry),
		.pop      (pop),
		.partner  (partner)
	);

	// The queue is never written when full and never read when empty.
	`MNE_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !q_stat.full, "queue written while full")
	`MNE_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, !q_stat.empty, "queue read while empty")
	// Every queued node has at least one partner to emit.
	`MNE_ASSERT_NOW(a_mask_set, clk, arst_n, push, push_entry.mask != '0, "empty node queued")
	// A write without a read leaves the queue non-empty in the next cycle.
	`MNE_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, !q_stat.empty, "queue lost a request")

endmodule

### src/mne_front.sv
// Front end: accepts node requests, splits the rank into row and column with
// an iterative divider, and classifies the eight neighbor slots. Uses mne_pkg.
module mne_front #(
	parameter int MAX_GRID_SIDE = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mne_node_if.sink                         node,
	input  logic [$clog2(MAX_GRID_SIDE):0]   grid_w,
	input  logic [$clog2(MAX_GRID_SIDE):0]   grid_h,
	input  logic                             q_full,
	output logic                             push,
	output mne_pkg::entry_t                  push_entry
);
	import mne_pkg::*;

	localparam int CW = $clog2(MAX_GRID_SIDE);
	localparam int DW = CW + 1;

	// One restoring division step: returns the new remainder and quotient bit.
	function automatic logic [CW:0] div_step(input logic [CW-1:0] rem,
		input logic dbit, input logic [DW-1:0] div);
		logic [DW-1:0] trial;
		logic          ge;
		logic [CW-1:0] nrem;
		trial = {rem, dbit};
		ge    = (trial >= div);
		nrem  = ge ? CW'(trial - div) : CW'(trial);
		return {nrem, ge};
	endfunction

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CW-1:0]        rem_q;
	logic [RANK_W-1:0]    quo_q;
	logic [RANK_W-1:0]    rank_q;

	logic                 valid_s1;
	logic [CW-1:0]        col_s1;
	logic [RANK_W-1:0]    row_s1;
	logic [RANK_W-1:0]    rank_s1;

	logic [CW:0]          step1, step2;
	logic [CW-1:0]        rem1, rem2;
	logic [RANK_W-1:0]    quo1, quo2;
	logic                 accept, fin, s1_free, s1_drain;

	logic                 c_hi, c_lo, r_in, r_up, r_dn;
	logic [DW-1:0]        w_m1c;
	logic [RANK_W:0]      row_x, h_x;
	logic [NUM_AXES-1:0]  keys, plus_ok, minus_ok;
	logic [NUM_SLOTS-1:0] mask;

	always_comb begin
		step1 = div_step(rem_q, quo_q[RANK_W-1], grid_w);
		rem1  = step1[CW:1];
		quo1  = {quo_q[RANK_W-2:0], step1[0]};
		step2 = div_step(rem1, quo1[RANK_W-1], grid_w);
		rem2  = step2[CW:1];
		quo2  = {quo1[RANK_W-2:0], step2[0]};
	end

	// Classification of the row/column held in stage 1.
	always_comb begin
		row_x = {1'b0, row_s1};
		h_x   = {{(RANK_W + 1 - DW){1'b0}}, grid_h};
		c_hi  = ({1'b0, col_s1} + DW'(1)) < grid_w;
		c_lo  = (col_s1 != '0);
		r_in  = row_x < h_x;
		r_up  = (row_x + (RANK_W + 1)'(1)) < h_x;
		r_dn  = (row_s1 != '0) && (row_x <= h_x);
		w_m1c = grid_w - DW'(1) - {1'b0, col_s1};

		keys[AXIS_HORIZ] = col_s1[0];
		keys[AXIS_VERT]  = row_s1[0];
		keys[AXIS_DIAG]  = (row_s1 < {{(RANK_W - CW){1'b0}}, col_s1}) ?
			row_s1[0] : col_s1[0];
		keys[AXIS_ANTI]  = (row_s1 < {{(RANK_W - DW){1'b0}}, w_m1c}) ?
			row_s1[0] : w_m1c[0];

		plus_ok[AXIS_HORIZ]  = c_hi & r_in;
		minus_ok[AXIS_HORIZ] = c_lo & r_in;
		plus_ok[AXIS_VERT]   = r_up;
		minus_ok[AXIS_VERT]  = r_dn;
		plus_ok[AXIS_DIAG]   = c_hi & r_up;
		minus_ok[AXIS_DIAG]  = c_lo & r_dn;
		plus_ok[AXIS_ANTI]   = c_lo & r_up;
		minus_ok[AXIS_ANTI]  = c_hi & r_dn;

		for (int a = 0; a < NUM_AXES; a++) begin
			mask[2*a]     = keys[a] ? minus_ok[a] : plus_ok[a];
			mask[2*a + 1] = keys[a] ? plus_ok[a] : minus_ok[a];
		end
	end

	// A node with no partner in the grid leaves stage 1 without a queue write.
	assign s1_drain   = valid_s1 && ((mask == '0) || !q_full);
	assign s1_free    = !valid_s1 || s1_drain;
	assign push       = valid_s1 && (mask != '0) && !q_full;
	assign push_entry = '{rank: rank_s1, mask: mask, keys: keys};

	assign fin        = busy_q && (cnt_q == DIV_CNT_LAST) && s1_free;
	assign node.ready = !busy_q || fin;
	assign accept     = node.valid && node.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (busy_q && (cnt_q != DIV_CNT_LAST)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fin) begin
				valid_s1 <= 1'b1;
			end else if (s1_drain) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q  <= '0;
			quo_q  <= node.node_rank;
			rank_q <= node.node_rank;
		end else if (busy_q && ((cnt_q != DIV_CNT_LAST) || fin)) begin
			rem_q <= rem2;
			quo_q <= quo2;
		end
		if (fin) begin
			col_s1  <= rem2;
			row_s1  <= quo2;
			rank_s1 <= rank_q;
		end
	end

endmodule

### src/mne_fifo.sv
// Short queue of classified nodes between the front end and the back end.
// Uses mne_pkg for the entry type, the depth and the status struct.
module mne_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mne_pkg::entry_t      push_entry,
	input  logic                 pop,
	output mne_pkg::entry_t      pop_entry,
	output mne_pkg::fifo_stat_t  stat
);
	import mne_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_entry  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### src/mne_back.sv
// Back end: walks the slot mask of one queued node and emits one partner per
// cycle while the receiver takes them, via a registered output. Uses mne_pkg.
module mne_back #(
	parameter int MAX_GRID_SIDE = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(MAX_GRID_SIDE):0]  grid_w,
	input  mne_pkg::fifo_stat_t             stat,
	input  mne_pkg::entry_t                 pop_entry,
	output logic                            pop,
	mne_partner_if.source                   partner
);
	import mne_pkg::*;

	localparam int DW = $clog2(MAX_GRID_SIDE) + 1;

	logic                 cur_valid_q;
	logic [RANK_W-1:0]    cur_rank_q;
	logic [NUM_SLOTS-1:0] cur_mask_q;
	logic [NUM_AXES-1:0]  cur_keys_q;

	logic                 out_valid_q;
	logic [RANK_W-1:0]    out_rank_q;
	logic [AXIS_W-1:0]    out_axis_q;
	logic                 out_last_q;

	logic [SLOT_W-1:0]    slot;
	logic [NUM_SLOTS-1:0] mask_next;
	logic [AXIS_W-1:0]    axis;
	logic                 neg, last, emit, take;
	logic [RANK_W-1:0]    w_x, offset, partner_calc;

	// Lowest pending slot comes out first.
	always_comb begin
		slot = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (cur_mask_q[i]) begin
				slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		mask_next = cur_mask_q & ~(NUM_SLOTS'(1) << slot);
		last      = (mask_next == '0);
		axis      = slot[SLOT_W-1:1];
		neg       = slot[0] ^ cur_keys_q[axis];
		w_x       = {{(RANK_W - DW){1'b0}}, grid_w};
		unique case (axis_t'(axis))
			AXIS_HORIZ: offset = RANK_W'(1);
			AXIS_VERT:  offset = w_x;
			AXIS_DIAG:  offset = w_x + RANK_W'(1);
			AXIS_ANTI:  offset = w_x - RANK_W'(1);
			default:    offset = '0;
		endcase
		partner_calc = neg ? (cur_rank_q - offset) : (cur_rank_q + offset);
	end

	assign emit = cur_valid_q && (!out_valid_q || partner.ready);
	assign take = !cur_valid_q || (emit && last);
	assign pop  = take && !stat.empty;

	assign partner.valid         = out_valid_q;
	assign partner.partner_rank  = out_rank_q;
	assign partner.exchange_axis = out_axis_q;
	assign partner.last_partner  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (emit && last) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (partner.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_rank_q <= pop_entry.rank;
			cur_mask_q <= pop_entry.mask;
			cur_keys_q <= pop_entry.keys;
		end else if (emit) begin
			cur_mask_q <= mask_next;
		end
		if (emit) begin
			out_rank_q <= partner_calc;
			out_axis_q <= axis;
			out_last_q <= last;
		end
	end

endmodule

### bench/exchange_order_monitor.sv
// Monitor for the mesh neighbor exchange order block: tracks the grid registers
// from the APB port, works out each node's partner list and checks every result.
// Depends on mne_pkg and on both channel interfaces.
module exchange_order_monitor
	import mne_pkg::*;
#(
	parameter int MAX_GRID_SIDE = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	mne_node_if                node_mon,
	mne_partner_if             partner_mon,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	output int                 failures,
	output int                 pending_results,
	output int                 results_checked
);

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		axis_t             axis;
		logic              last;
	} partner_t;

	partner_t          expected_partners[$];
	partner_t          oldest;
	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;
	logic [CFG_W-1:0]  read_value;
	int                mismatch_count = 0;
	int                checked_count = 0;
	int                cycle_no = 0;

	task automatic report_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycle_no, what);
		mismatch_count++;
	endtask

	function automatic int side_of(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > MAX_GRID_SIDE)
			return MAX_GRID_SIDE;
		return int'(v);
	endfunction

	// Queues the partners of one node in the order the block must emit them.
	function automatic void plan_exchange(input logic [RANK_W-1:0] rank);
		int       w, h, c, r, key, dx, dy, x, y, n, a, s;
		partner_t found [NUM_SLOTS];
		w = side_of(width_reg);
		h = side_of(height_reg);
		c = int'(rank) % w;
		r = int'(rank) / w;
		n = 0;
		for (a = 0; a < NUM_AXES; a++) begin
			case (axis_t'(a))
				AXIS_HORIZ: begin
					dx = 1; dy = 0; key = c;
				end
				AXIS_VERT: begin
					dx = 0; dy = 1; key = r;
				end
				AXIS_DIAG: begin
					dx = 1; dy = 1; key = (r < c) ? r : c;
				end
				default: begin
					dx = -1; dy = 1; key = (r < w - 1 - c) ? r : w - 1 - c;
				end
			endcase
			// An odd key swaps the two neighbors of this axis.
			if (key % 2 != 0) begin
				dx = -dx;
				dy = -dy;
			end
			for (s = 0; s < 2; s++) begin
				x = (s == 0) ? c + dx : c - dx;
				y = (s == 0) ? r + dy : r - dy;
				if (x >= 0 && y >= 0 && x < w && y < h) begin
					found[n].rank = RANK_W'(y * w + x);
					found[n].axis = axis_t'(a);
					found[n].last = 1'b0;
					n++;
				end
			end
		end
		if (n > 0)
			found[n-1].last = 1'b1;
		for (a = 0; a < n; a++)
			expected_partners = {expected_partners, found[a]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_partners.delete();
			width_reg = CFG_W'(1);
			height_reg = CFG_W'(1);
			pending_results <= 0;
		end else begin
			cycle_no++;
			if (partner_mon.valid && partner_mon.ready) begin
				if (expected_partners.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: rank %0d axis %0d",
						partner_mon.partner_rank, partner_mon.exchange_axis));
				end else begin
					oldest = expected_partners.pop_front();
					checked_count++;
					if (partner_mon.partner_rank !== oldest.rank)
						report_mismatch($sformatf("partner_rank %0d, expected %0d",
							partner_mon.partner_rank, oldest.rank));
					if (partner_mon.exchange_axis !== oldest.axis)
						report_mismatch($sformatf("exchange_axis %0d, expected %0d",
							partner_mon.exchange_axis, oldest.axis));
					if (partner_mon.last_partner !== oldest.last)
						report_mismatch($sformatf("last_partner %0b, expected %0b",
							partner_mon.last_partner, oldest.last));
				end
			end
			if (node_mon.valid && node_mon.ready)
				plan_exchange(node_mon.node_rank);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[PADDR_W-1:2] == REG_GRID_WIDTH)
						width_reg = pwdata[CFG_W-1:0];
					else
						height_reg = pwdata[CFG_W-1:0];
				end else begin
					read_value = (paddr[PADDR_W-1:2] == REG_GRID_WIDTH) ? width_reg : height_reg;
					if (prdata !== PDATA_W'(read_value))
						report_mismatch($sformatf("register read at %0d gave %0h, expected %0h",
							paddr, prdata, read_value));
				end
			end
			pending_results <= expected_partners.size();
		end
	end

	always @(posedge clk) begin
		failures <= mismatch_count;
		results_checked <= checked_count;
	end

endmodule

### bench/tb_mesh_neighbor_exchange_order.sv
// Top of the mesh neighbor exchange order testbench: clock, reset, APB register
// writes, node requests and result back-pressure, and the final verdict.
// Depends on mne_pkg, both channel interfaces, the block and exchange_order_monitor.
module tb_mesh_neighbor_exchange_order;
	import mne_pkg::*;

	localparam int MAX_GRID_SIDE      = 64;
	localparam int NUM_SETTINGS       = 8;
	localparam int RANDOM_PER_SETTING = 18;
	// Length of the long receiver hold-off that fills the block's queue.
	localparam int HOLD_CYCLES        = 300;
	// Covers requests still in the divider or stage 1 that produce no result.
	localparam int SETTLE_CYCLES      = 64;
	localparam int CYCLE_LIMIT        = 400000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int failures;
	int pending_results;
	int results_checked;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int send_idle_pct;
	int stall_pct;
	// Each increment asks the receiver process for one long hold-off.
	int hold_requests;
	int hold_seen;
	int hold_left;
	int cycle_count = 0;
	int nodes_sent;
	int config_writes;

	logic [CFG_W-1:0] grid_w [NUM_SETTINGS];
	logic [CFG_W-1:0] grid_h [NUM_SETTINGS];

	mne_node_if    node_ch();
	mne_partner_if partner_ch();

	mesh_neighbor_exchange_order #(
		.MAX_GRID_SIDE(MAX_GRID_SIDE)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.node    (node_ch),
		.partner (partner_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	exchange_order_monitor #(
		.MAX_GRID_SIDE(MAX_GRID_SIDE)
	) order_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.node_mon        (node_ch),
		.partner_mon     (partner_ch),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.failures        (failures),
		.pending_results (pending_results),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The watchdog: a run that has not ended by the limit has lost results.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding",
			cycle_count, pending_results);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// The receiver: random stalls at the current rate, and a long hold-off
	// whenever the stimulus asks for one. The hold-off is counted here so the
	// sender can keep offering requests while the block backs up.
	initial begin
		partner_ch.ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				partner_ch.ready <= 1'b0;
			end else begin
				partner_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic int side_of(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > MAX_GRID_SIDE)
			return MAX_GRID_SIDE;
		return int'(v);
	endfunction

	// Mostly nodes inside the grid; the rest are corners, nodes on the row just
	// below the grid, and ranks from anywhere in the 12-bit range.
	function automatic logic [RANK_W-1:0] pick_rank(input int w, input int h);
		int roll;
		int cells;
		roll = $urandom_range(99);
		cells = w * h;
		if (roll < 70)
			return RANK_W'($urandom_range(cells - 1));
		if (roll < 80)
			return RANK_W'(cells + $urandom_range(w - 1));
		if (roll < 90) begin
			case ($urandom_range(3))
				0: return '0;
				1: return RANK_W'(w - 1);
				2: return RANK_W'((h - 1) * w);
				default: return RANK_W'(cells - 1);
			endcase
		end
		return RANK_W'($urandom_range(4095));
	endfunction

	// Called at a clock edge; returns at the edge where the request is taken,
	// leaving valid high so that the next request can follow without a gap.
	task automatic send_node(input logic [RANK_W-1:0] rank);
		while ($urandom_range(99) < send_idle_pct) begin
			node_ch.valid <= 1'b0;
			@(posedge clk);
		end
		node_ch.valid <= 1'b1;
		node_ch.node_rank <= rank;
		@(posedge clk);
		while (!node_ch.ready)
			@(posedge clk);
		nodes_sent++;
	endtask

	// Stops offering requests and waits until every predicted result has come
	// and any request without results has left the block.
	task automatic wait_drained();
		node_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		// Upper data bits are random; only the low seven bits reach the register.
		pwdata <= {(PDATA_W - CFG_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		config_writes++;
	endtask

	task automatic apb_read(input reg_idx_t idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// One grid setting: drain, program and read back the registers, then a run
	// of random nodes. Optionally the receiver holds off for a long stretch at
	// the start, or the sender pauses halfway until all results are in.
	task automatic run_setting(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
		input bit with_hold, input bit with_pause);
		int we;
		int he;
		int i;
		wait_drained();
		apb_write(REG_GRID_WIDTH, w);
		apb_write(REG_GRID_HEIGHT, h);
		apb_read(REG_GRID_WIDTH);
		apb_read(REG_GRID_HEIGHT);
		we = side_of(w);
		he = side_of(h);
		if (with_hold)
			hold_requests <= hold_requests + 1;
		for (i = 0; i < RANDOM_PER_SETTING; i++) begin
			if (with_pause && i == RANDOM_PER_SETTING / 2)
				wait_drained();
			send_node(pick_rank(we, he));
		end
	endtask

	initial begin
		int k;
		int phase;
		node_ch.valid = 1'b0;
		node_ch.node_rank = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests = 0;
		nodes_sent = 0;
		config_writes = 0;
		arst_n = 1'b0;

		// Full-size and degenerate grids, register values of zero and of the
		// 7-bit maximum, a tiny grid, and two random ones.
		grid_w[0] = 7'd64;  grid_h[0] = 7'd64;
		grid_w[1] = 7'd1;   grid_h[1] = 7'd64;
		grid_w[2] = 7'd64;  grid_h[2] = 7'd1;
		grid_w[3] = 7'd0;   grid_h[3] = 7'd127;
		grid_w[4] = 7'd127; grid_h[4] = 7'd0;
		grid_w[5] = 7'd2;   grid_h[5] = 7'd2;
		grid_w[6] = CFG_W'($urandom_range(1, 64));
		grid_h[6] = CFG_W'($urandom_range(1, 64));
		grid_w[7] = CFG_W'($urandom_range(1, 64));
		grid_h[7] = CFG_W'($urandom_range(1, 64));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values read back, then the 1x1 grid: no node has a neighbor,
		// and a rank far outside the grid gives nothing either.
		apb_read(REG_GRID_WIDTH);
		apb_read(REG_GRID_HEIGHT);
		send_node('0);
		send_node('1);

		// A 5x4 grid, walked node by node, covers every corner, edge and odd or
		// even key on each axis. Nodes on the row below the grid only have
		// partners above them, and the top rank has none at all.
		wait_drained();
		apb_write(REG_GRID_WIDTH, 7'd5);
		apb_write(REG_GRID_HEIGHT, 7'd4);
		for (k = 0; k < 20; k++)
			send_node(RANK_W'(k));
		send_node(RANK_W'(21));
		send_node(RANK_W'(24));
		send_node('1);

		// Four idle mixes, two grid settings each. The long hold-off comes in
		// the mix without idling so the queue fills as fast as possible.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 54;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct <= 54;
				end
				default: begin
					send_idle_pct = 34;
					stall_pct <= 34;
				end
			endcase
			run_setting(grid_w[2*phase], grid_h[2*phase], 1'b0, phase == 1);
			run_setting(grid_w[2*phase+1], grid_h[2*phase+1], phase == 0, 1'b0);
		end

		wait_drained();
		$display("Sent %0d node requests and checked %0d partner results over %0d register writes.",
			nodes_sent, results_checked, config_writes);
		$display("Grids ranged from 1x1 to 64x64, out-of-range register values included, under four idle mixes.");
		if (failures == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
